### sv/mmps_pkg.sv
// ----------------------------------------------------------------------------
// mmps_pkg: shared types and constants for the meeting point search
// Field widths, register codes and the control part of a chain beat.
// ----------------------------------------------------------------------------
`default_nettype none

package mmps_pkg;

   localparam int COORD_W    = 11;
   localparam int TOTAL_W    = 21;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
   localparam logic [COORD_W-1:0] SIDE_RESET = 11'd1024;

   // register indexes, taken from paddr bit 2
   localparam logic CSR_NUM_STREETS = 1'b0;
   localparam logic CSR_NUM_AVENUES = 1'b1;

   // control bits that travel with each beat along the cell chain
   typedef struct packed {
      logic coord_vld;  // beat carries a friend coordinate
      logic first;      // first coordinate of a pass, restarts the sums
      logic tok_vld;    // beat carries the running best (token)
      logic tok_found;  // token already holds a legal position
   } beat_ctl_type;

endpackage

`default_nettype wire

### sv/mmps_if.sv
// ----------------------------------------------------------------------------
// mmps_if: request and response channels
// Valid/ready channels for friend beats in and meeting point beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmps_req_if import mmps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] friend_street;
   logic [COORD_W-1:0] friend_avenue;
   logic               last_friend;

   modport source (output valid, output friend_street, output friend_avenue,
                   output last_friend, input ready);
   modport sink   (input valid, input friend_street, input friend_avenue,
                   input last_friend, output ready);
endinterface

interface mmps_rsp_if import mmps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] best_street;
   logic [COORD_W-1:0] best_avenue;
   logic [TOTAL_W-1:0] min_total_distance;

   modport source (output valid, output best_street, output best_avenue,
                   output min_total_distance, input ready);
   modport sink   (input valid, input best_street, input best_avenue,
                   input min_total_distance, output ready);
endinterface

`default_nettype wire

### sv/mmps_csr.sv
// ----------------------------------------------------------------------------
// mmps_csr: configuration registers
// APB-style access to the searched grid size.
// ----------------------------------------------------------------------------
`default_nettype none

module mmps_csr import mmps_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [COORD_W-1:0]    num_streets,
   output logic      [COORD_W-1:0]    num_avenues
);

   logic [COORD_W-1:0] streets_ff, streets_in;
   logic [COORD_W-1:0] avenues_ff, avenues_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      streets_in = streets_ff;
      avenues_in = avenues_ff;
      prdata     = '0;
      unique case (paddr[2])
         CSR_NUM_STREETS: begin
            prdata = CSR_DATA_W'(streets_ff);
            if (wr_en) streets_in = pwdata[COORD_W-1:0];
         end
         CSR_NUM_AVENUES: begin
            prdata = CSR_DATA_W'(avenues_ff);
            if (wr_en) avenues_in = pwdata[COORD_W-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streets_ff <= SIDE_RESET;
         avenues_ff <= SIDE_RESET;
      end else begin
         streets_ff <= streets_in;
         avenues_ff <= avenues_in;
      end
   end

   assign num_streets = streets_ff;
   assign num_avenues = avenues_ff;

endmodule

`default_nettype wire

### sv/mmps_cell.sv
// ----------------------------------------------------------------------------
// mmps_cell: one candidate position of the search chain
// Sums distances of passing coordinates, updates the passing token.
// ----------------------------------------------------------------------------
`default_nettype none

module mmps_cell import mmps_pkg::*; #(
   parameter int CELL_IDX = 0,
   parameter int PW       = 12,
   parameter int AW       = 23
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [PW-1:0]      base,
   input  wire logic [PW-1:0]      side,
   input  wire beat_ctl_type       ctl_in,
   input  wire logic [COORD_W-1:0] coord_in,
   input  wire logic [AW-1:0]      sum_in,
   input  wire logic [PW-1:0]      pos_in,
   output beat_ctl_type            ctl_out,
   output logic      [COORD_W-1:0] coord_out,
   output logic      [AW-1:0]      sum_out,
   output logic      [PW-1:0]      pos_out
);

   logic [PW-1:0]      pos;
   logic [PW-1:0]      coord_ext;
   logic [PW-1:0]      delta;
   logic               pos_ok;
   logic               take;
   logic [AW-1:0]      acc_ff, acc_in;
   beat_ctl_type       ctl_ff, ctl_fwd_in;
   logic [COORD_W-1:0] coord_ff;
   logic [AW-1:0]      sum_ff, sum_fwd_in;
   logic [PW-1:0]      pos_ff, pos_fwd_in;

   always_comb begin
      pos       = base + PW'(CELL_IDX);
      pos_ok    = pos <= side;
      coord_ext = PW'(coord_in);
      delta     = (coord_ext >= pos) ? coord_ext - pos : pos - coord_ext;

      acc_in = acc_ff;
      if (ctl_in.coord_vld) begin
         acc_in = ctl_in.first ? AW'(delta) : acc_ff + AW'(delta);
      end

      // strict compare keeps the lowest position on ties
      take = ctl_in.tok_vld && pos_ok && (!ctl_in.tok_found || acc_ff < sum_in);

      ctl_fwd_in           = ctl_in;
      ctl_fwd_in.tok_found = ctl_in.tok_found || take;
      sum_fwd_in           = take ? acc_ff : sum_in;
      pos_fwd_in           = take ? pos    : pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_fwd_in;
      end
      acc_ff   <= acc_in;
      coord_ff <= coord_in;
      sum_ff   <= sum_fwd_in;
      pos_ff   <= pos_fwd_in;
   end

   assign ctl_out   = ctl_ff;
   assign coord_out = coord_ff;
   assign sum_out   = sum_ff;
   assign pos_out   = pos_ff;

endmodule

`default_nettype wire

### sv/manhattan_meeting_point_search.sv
// ----------------------------------------------------------------------------
// manhattan_meeting_point_search: grid point with least total distance
// Stores friend locations, then searches each axis with a chain of cells.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    friend_street, friend_avenue, last_friend
//   rsp_chan  out        valid / ready    best_street, best_avenue, min_total_distance
//   csr       in         psel / penable   paddr, pwdata, prdata (num_streets, num_avenues)
//
// friend beats load at one per cycle into the friend memory
// after the last beat each axis is searched in passes of NUM_CELLS positions:
//   per axis ceil(side / NUM_CELLS) passes,
//   the friend memory read port streams one coordinate per cycle into the chain
// req ready stays low from the last beat until the result enters the output register
// a waiting result does not block loading of the next set
// synchronous reset, no clearing pass: memory entries are read only below the count
// ----------------------------------------------------------------------------
`default_nettype none

module manhattan_meeting_point_search import mmps_pkg::*; #(
   parameter int MAX_SIDE    = 1024,
   parameter int MAX_FRIENDS = 1024,
   parameter int NUM_CELLS   = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mmps_req_if.sink                   req_chan,
   mmps_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // widths follow from the parameters
   localparam int CNT_W  = $clog2(MAX_FRIENDS + 1);
   localparam int IDX_W  = (MAX_FRIENDS > 1) ? $clog2(MAX_FRIENDS) : 1;
   localparam int PW_RAW = $clog2(MAX_SIDE + NUM_CELLS) + 1;
   localparam int PW     = (PW_RAW > COORD_W + 1) ? PW_RAW : COORD_W + 1;
   localparam int AW     = PW + CNT_W;
   localparam int SUM_W  = (AW + 1 > TOTAL_W) ? AW + 1 : TOTAL_W;

   localparam logic AXIS_STREET = 1'b0;
   localparam logic AXIS_AVENUE = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,   // taking friend beats
      ST_FEED,   // streaming stored coordinates into the chain
      ST_TOKEN,  // token follows the last coordinate
      ST_WAIT,   // token travels down the chain
      ST_DONE    // both axes searched, hand over to the output register
   } state_type;

   // configuration
   logic [COORD_W-1:0] num_streets;
   logic [COORD_W-1:0] num_avenues;

   mmps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .num_streets (num_streets),
      .num_avenues (num_avenues)
   );

   // sides clamped to 1..MAX_SIDE
   function automatic logic [PW-1:0] clamp_side(input logic [COORD_W-1:0] side);
      logic [PW-1:0] ext;
      ext = PW'(side);
      if (ext == '0) return PW'(1);
      if (ext > PW'(MAX_SIDE)) return PW'(MAX_SIDE);
      return ext;
   endfunction

   // sequencer state
   state_type          state_ff,       state_in;
   logic [CNT_W-1:0]   count_ff,       count_in;
   logic [CNT_W-1:0]   rd_idx_ff,      rd_idx_in;
   logic               axis_ff,        axis_in;
   logic [PW-1:0]      base_ff,        base_in;
   logic               issue_vld_ff,   issue_vld_in;
   logic               issue_first_ff, issue_first_in;
   logic               tok_pend_ff,    tok_pend_in;
   logic               best_found_ff,  best_found_in;
   logic [AW-1:0]      best_sum_ff,    best_sum_in;
   logic [PW-1:0]      best_pos_ff,    best_pos_in;
   logic [AW-1:0]      st_sum_ff,      st_sum_in;
   logic [PW-1:0]      st_pos_ff,      st_pos_in;
   logic               rsp_valid_ff,   rsp_valid_in;
   logic [COORD_W-1:0] rsp_street_ff,  rsp_street_in;
   logic [COORD_W-1:0] rsp_avenue_ff,  rsp_avenue_in;
   logic [TOTAL_W-1:0] rsp_total_ff,   rsp_total_in;

   logic               req_accept;
   logic               mem_we;
   logic [PW-1:0]      side_sel;
   logic [PW-1:0]      next_base;
   logic [SUM_W-1:0]   total_sum;

   // friend memory, {street, avenue} per entry
   logic [2*COORD_W-1:0] friend_mem [MAX_FRIENDS];
   logic [2*COORD_W-1:0] rd_data_ff;

   // chain links, index 0 is the injected beat
   beat_ctl_type       ctl_link   [NUM_CELLS+1];
   logic [COORD_W-1:0] coord_link [NUM_CELLS+1];
   logic [AW-1:0]      sum_link   [NUM_CELLS+1];
   logic [PW-1:0]      pos_link   [NUM_CELLS+1];

   assign req_accept = req_chan.valid && req_chan.ready;
   assign side_sel   = (axis_ff == AXIS_AVENUE) ? clamp_side(num_avenues)
                                                : clamp_side(num_streets);
   assign next_base  = base_ff + PW'(NUM_CELLS);
   assign total_sum  = SUM_W'(st_sum_ff) + SUM_W'(best_sum_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_idx_in      = rd_idx_ff;
      axis_in        = axis_ff;
      base_in        = base_ff;
      issue_vld_in   = 1'b0;
      issue_first_in = 1'b0;
      tok_pend_in    = 1'b0;
      best_found_in  = best_found_ff;
      best_sum_in    = best_sum_ff;
      best_pos_in    = best_pos_ff;
      st_sum_in      = st_sum_ff;
      st_pos_in      = st_pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_street_in  = rsp_street_ff;
      rsp_avenue_in  = rsp_avenue_ff;
      rsp_total_in   = rsp_total_ff;
      mem_we         = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               // a full store drops the beat but still honors last_friend
               if (count_ff < CNT_W'(MAX_FRIENDS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_chan.last_friend) begin
                  axis_in       = AXIS_STREET;
                  base_in       = PW'(1);
                  best_found_in = 1'b0;
                  rd_idx_in     = '0;
                  state_in      = ST_FEED;
               end
            end
         end
         ST_FEED: begin
            issue_vld_in   = 1'b1;
            issue_first_in = (rd_idx_ff == '0);
            rd_idx_in      = rd_idx_ff + 1'b1;
            if (CNT_W'(rd_idx_ff + 1'b1) == count_ff) begin
               rd_idx_in = '0;
               state_in  = ST_TOKEN;
            end
         end
         ST_TOKEN: begin
            tok_pend_in = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            if (ctl_link[NUM_CELLS].tok_vld) begin
               best_found_in = ctl_link[NUM_CELLS].tok_found;
               best_sum_in   = sum_link[NUM_CELLS];
               best_pos_in   = pos_link[NUM_CELLS];
               if (next_base > side_sel) begin
                  if (axis_ff == AXIS_STREET) begin
                     // street axis done, start on avenues
                     st_sum_in     = sum_link[NUM_CELLS];
                     st_pos_in     = pos_link[NUM_CELLS];
                     axis_in       = AXIS_AVENUE;
                     base_in       = PW'(1);
                     best_found_in = 1'b0;
                     state_in      = ST_FEED;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  base_in  = next_base;
                  state_in = ST_FEED;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_street_in = st_pos_ff[COORD_W-1:0];
               rsp_avenue_in = best_pos_ff[COORD_W-1:0];
               // saturate the reported total, the point is chosen on exact sums
               rsp_total_in  = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                               : total_sum[TOTAL_W-1:0];
               count_in      = '0;
               state_in      = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         axis_ff      <= AXIS_STREET;
         issue_vld_ff <= 1'b0;
         tok_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         axis_ff      <= axis_in;
         issue_vld_ff <= issue_vld_in;
         tok_pend_ff  <= tok_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff        <= base_in;
      issue_first_ff <= issue_first_in;
      best_found_ff  <= best_found_in;
      best_sum_ff    <= best_sum_in;
      best_pos_ff    <= best_pos_in;
      st_sum_ff      <= st_sum_in;
      st_pos_ff      <= st_pos_in;
      rsp_street_ff  <= rsp_street_in;
      rsp_avenue_ff  <= rsp_avenue_in;
      rsp_total_ff   <= rsp_total_in;
   end

   // one write port for loading, one registered read port for streaming
   always_ff @(posedge clock) begin
      if (mem_we) begin
         friend_mem[count_ff[IDX_W-1:0]] <= {req_chan.friend_street,
                                             req_chan.friend_avenue};
      end
      rd_data_ff <= friend_mem[rd_idx_ff[IDX_W-1:0]];
   end

   // injected beat: coordinate in the cycle after its read, token right behind the last
   assign ctl_link[0].coord_vld = issue_vld_ff;
   assign ctl_link[0].first     = issue_first_ff;
   assign ctl_link[0].tok_vld   = tok_pend_ff;
   assign ctl_link[0].tok_found = best_found_ff;
   assign coord_link[0] = (axis_ff == AXIS_AVENUE) ? rd_data_ff[COORD_W-1:0]
                                                   : rd_data_ff[2*COORD_W-1:COORD_W];
   assign sum_link[0]   = best_sum_ff;
   assign pos_link[0]   = best_pos_ff;

   // cell k evaluates position base + k of the current axis
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      mmps_cell #(
         .CELL_IDX (k),
         .PW       (PW),
         .AW       (AW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .base      (base_ff),
         .side      (side_sel),
         .ctl_in    (ctl_link[k]),
         .coord_in  (coord_link[k]),
         .sum_in    (sum_link[k]),
         .pos_in    (pos_link[k]),
         .ctl_out   (ctl_link[k+1]),
         .coord_out (coord_link[k+1]),
         .sum_out   (sum_link[k+1]),
         .pos_out   (pos_link[k+1])
      );
   end

   // channel outputs
   assign req_chan.ready              = (state_ff == ST_LOAD);
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.best_street        = rsp_street_ff;
   assign rsp_chan.best_avenue        = rsp_avenue_ff;
   assign rsp_chan.min_total_distance = rsp_total_ff;

   // a token leaves the chain only while the sequencer waits for it
   a_token_in_wait: assert property (@(posedge clock) disable iff (reset)
      ctl_link[NUM_CELLS].tok_vld |-> state_ff == ST_WAIT)
      else $error("token left the chain outside the wait state");

   // the last friend beat starts the street search
   a_last_starts_search: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.last_friend) |=> state_ff == ST_FEED)
      else $error("last friend beat did not start the search");

   // a result beat appears only when both axes are done
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat raised outside the done state");

endmodule

`default_nettype wire

### verif/manhattan_meeting_point_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manhattan_meeting_point_search_checker: scoreboard for the meeting point search
// Follows friend beats and register writes, works out the meeting point of
// each finished set and compares it with the result beats in order.
// ----------------------------------------------------------------------------

module manhattan_meeting_point_search_checker import mmps_pkg::*; #(
   parameter int MAX_SIDE    = 1024,
   parameter int MAX_FRIENDS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mmps_req_if                        req_mon,
   mmps_rsp_if                        rsp_mon,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         error_count,
   output int                         pending_count
);

   typedef struct packed {
      logic [COORD_W-1:0] street;
      logic [COORD_W-1:0] avenue;
      logic [TOTAL_W-1:0] total;
   } meeting_point_type;

   logic [COORD_W-1:0] street_store [MAX_FRIENDS];
   logic [COORD_W-1:0] avenue_store [MAX_FRIENDS];
   int                 friends_held;
   logic [COORD_W-1:0] streets_cfg;
   logic [COORD_W-1:0] avenues_cfg;
   meeting_point_type  meeting_q [$];
   meeting_point_type  want;
   meeting_point_type  found;
   int                 mismatches = 0;

   function automatic int clamp_side(input logic [COORD_W-1:0] side);
      if (side == 0) return 1;
      if (side > MAX_SIDE) return MAX_SIDE;
      return int'(side);
   endfunction

   // lowest position on one axis with the least summed distance
   function automatic longint axis_minimum(input bit on_avenue, input int side,
                                           output logic [COORD_W-1:0] pos);
      longint best;
      longint sum;
      int     c;
      best = 0;
      pos  = COORD_W'(1);
      for (int p = 1; p <= side; p++) begin
         sum = 0;
         for (int i = 0; i < friends_held; i++) begin
            c = on_avenue ? int'(avenue_store[i]) : int'(street_store[i]);
            sum += (c > p) ? c - p : p - c;
         end
         if (p == 1 || sum < best) begin
            best = sum;
            pos  = p[COORD_W-1:0];
         end
      end
      return best;
   endfunction

   // the distance separates per axis, so each axis is minimized on its own
   function automatic meeting_point_type locate_meeting_point();
      meeting_point_type mp;
      longint            total;
      total  = axis_minimum(1'b0, clamp_side(streets_cfg), mp.street);
      total += axis_minimum(1'b1, clamp_side(avenues_cfg), mp.avenue);
      mp.total = (total > longint'(TOTAL_MAX)) ? TOTAL_MAX : total[TOTAL_W-1:0];
      return mp;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         friends_held = 0;
         streets_cfg  = SIDE_RESET;
         avenues_cfg  = SIDE_RESET;
         meeting_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[2])
               CSR_NUM_STREETS: streets_cfg = pwdata[COORD_W-1:0];
               CSR_NUM_AVENUES: avenues_cfg = pwdata[COORD_W-1:0];
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            found = '{rsp_mon.best_street, rsp_mon.best_avenue, rsp_mon.min_total_distance};
            if (meeting_q.size() == 0) begin
               $error("result beat with nothing expected: street %0d avenue %0d total %0d",
                      found.street, found.avenue, found.total);
               mismatches++;
            end else begin
               want = meeting_q.pop_front();
               if (found.street !== want.street) begin
                  $error("best_street: expected %0d, actual %0d", want.street, found.street);
                  mismatches++;
               end
               if (found.avenue !== want.avenue) begin
                  $error("best_avenue: expected %0d, actual %0d", want.avenue, found.avenue);
                  mismatches++;
               end
               if (found.total !== want.total) begin
                  $error("min_total_distance: expected %0d, actual %0d",
                         want.total, found.total);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            // a friend beyond a full store is dropped
            if (friends_held < MAX_FRIENDS) begin
               street_store[friends_held] = req_mon.friend_street;
               avenue_store[friends_held] = req_mon.friend_avenue;
               friends_held++;
            end
            if (req_mon.last_friend) begin
               meeting_q.push_back(locate_meeting_point());
               friends_held = 0;
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= meeting_q.size();
   end

endmodule

### verif/manhattan_meeting_point_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manhattan_meeting_point_search_tb: top of the meeting point search bench
// Loads friend sets under several grid sizes and idle patterns, including a
// long output hold and an overflowing set; the checker scores every result.
// ----------------------------------------------------------------------------

module manhattan_meeting_point_search_tb;
   import mmps_pkg::*;

   localparam int MAX_SIDE     = 1024;
   localparam int MAX_FRIENDS  = 1024;
   localparam int CLOCK_PERIOD = 8;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_BEATS  = 8;     // least random beats per phase, about 1100 with the full set
   localparam int HOLD_CYCLES  = 1500;  // long output hold, fills the block

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int error_count;
   int pending_count;

   // idle and hold controls, shared between stimulus and receiver
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_len       = 0;
   int hold_seq       = 0;

   // grid size per random phase: zero, oversize and one-wide sides included
   int phase_streets [NUM_PHASES] = '{5, 0, 64, 1, 2047, 200, 33, 1024};
   int phase_avenues [NUM_PHASES] = '{9, 2047, 33, 1, 0, 300, 32, 1024};

   mmps_req_if req_chan ();
   mmps_rsp_if rsp_chan ();

   manhattan_meeting_point_search #(
      .MAX_SIDE    (MAX_SIDE),
      .MAX_FRIENDS (MAX_FRIENDS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   manhattan_meeting_point_search_checker #(
      .MAX_SIDE    (MAX_SIDE),
      .MAX_FRIENDS (MAX_FRIENDS)
   ) scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("** manhattan_meeting_point_search: FAILED **");
      $finish;
   end

   // receiver: random stalls, plus a long hold counted here when requested
   initial begin : receiver
      int seen_seq;
      int hold_left;
      seen_seq = 0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_seq) begin
            seen_seq  = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // one friend beat, then a random gap on the sender side
   task automatic send_friend(input logic [COORD_W-1:0] street,
                              input logic [COORD_W-1:0] avenue, input bit last);
      req_chan.valid         <= 1'b1;
      req_chan.friend_street <= street;
      req_chan.friend_avenue <= avenue;
      req_chan.last_friend   <= last;
      do @(posedge clock); while (!req_chan.ready);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // register write: setup phase, access phase until pready, then back to idle
   task automatic csr_write(input logic reg_idx, input logic [COORD_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      data[COORD_W-1:0] = value;  // upper bits are random noise
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering and wait until every expected result is out
   task automatic drain(input int settle);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (settle) @(posedge clock);
   endtask

   // coordinate mostly in 1..side+4 with side clamped to 1..MAX_SIDE, sometimes anywhere in 11 bits
   function automatic logic [COORD_W-1:0] rand_coord(input int side);
      int limit;
      limit = (side < 1) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
      case ($urandom_range(9))
         0: return COORD_W'($urandom_range(2047, 0));
         1: return $urandom_range(1) ? 11'h7FF : 11'h000;
         default: return COORD_W'($urandom_range(limit + 4, 1));
      endcase
   endfunction

   // one complete friend set, mostly short, now and then longer
   task automatic send_random_set(input int side_s, input int side_a, output int n);
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < n; i++)
         send_friend(rand_coord(side_s), rand_coord(side_a), i == n - 1);
   endtask

   initial begin : stimulus
      int sent;
      int sets;
      int n;
      reset                  = 1'b1;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      req_chan.valid         = 1'b0;
      req_chan.friend_street = '0;
      req_chan.friend_avenue = '0;
      req_chan.last_friend   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets on the reset grid of 1024 by 1024
      send_friend(11'd1, 11'd1, 1'b1);          // corner, zero distance
      send_friend(11'd1024, 11'd1024, 1'b1);    // far corner
      send_friend(11'd0, 11'd0, 1'b1);          // below the grid
      send_friend(11'h7FF, 11'h7FF, 1'b1);      // above the grid
      send_friend(11'd1, 11'd5, 1'b0);          // tie along streets
      send_friend(11'd3, 11'd5, 1'b1);
      send_friend(11'd10, 11'd20, 1'b0);        // square, ties on both axes
      send_friend(11'd30, 11'd40, 1'b0);
      send_friend(11'd10, 11'd40, 1'b0);
      send_friend(11'd30, 11'd20, 1'b1);
      send_friend(11'h555, 11'h2AA, 1'b0);      // alternating bit patterns
      send_friend(11'h2AA, 11'h555, 1'b0);
      send_friend(11'h7FF, 11'h000, 1'b0);
      send_friend(11'h000, 11'h7FF, 1'b1);
      send_friend(11'd1024, 11'd1, 1'b0);
      send_friend(11'd1, 11'd1024, 1'b1);

      // random phases: new grid each time, idle pattern cycles through four modes
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain(4);
         csr_write(CSR_NUM_STREETS, phase_streets[ph][COORD_W-1:0]);
         csr_write(CSR_NUM_AVENUES, phase_avenues[ph][COORD_W-1:0]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 49; end
            default: begin send_idle_pct = 19; recv_stall_pct <= 19; end
         endcase
         // back-pressure: output held while the sender keeps going
         if (ph == 6) begin
            hold_len <= HOLD_CYCLES;
            hold_seq <= hold_seq + 1;
         end
         sent = 0;
         sets = 0;
         // the held phase needs a third set so that the input stalls behind the output
         while (sent < PHASE_BEATS || (ph == 6 && sets < 3)) begin
            send_random_set(phase_streets[ph], phase_avenues[ph], n);
            sent += n;
            sets++;
         end
      end

      // overflowing set on a 1 by 1 grid: store full, zero side, saturated total
      drain(4);
      csr_write(CSR_NUM_STREETS, 11'd0);
      csr_write(CSR_NUM_AVENUES, 11'd1);
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      for (int i = 0; i < MAX_FRIENDS; i++) begin
         if ($urandom_range(9) == 0)
            send_friend(rand_coord(MAX_SIDE), rand_coord(MAX_SIDE), 1'b0);
         else
            send_friend(11'h7FF, 11'h7FF, 1'b0);
      end
      // these are dropped, the last one still starts the search
      for (int i = 0; i < 6; i++)
         send_friend(11'd0, 11'd0, i == 5);

      drain(100);
      if (error_count == 0 && pending_count == 0)
         $display("** manhattan_meeting_point_search: PASSED **");
      else
         $display("** manhattan_meeting_point_search: FAILED **");
      $finish;
   end

endmodule

### sim.f
sv/mmps_pkg.sv
sv/mmps_if.sv
sv/mmps_csr.sv
sv/mmps_cell.sv
sv/manhattan_meeting_point_search.sv
verif/manhattan_meeting_point_search_checker.sv
verif/manhattan_meeting_point_search_tb.sv
